// ----- hdl/assert_macros.svh -----
// Assertion macros used by the top level RTL file of the head pose block.
// Needs a clk and an active-low rst_n in the scope of the user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled during reset.
`define HPQ_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("hpq assertion failed");

// Clocked assertion that is also checked during reset.
`define HPQ_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("hpq assertion failed");

`endif

// ----- hdl/hpq_pkg.sv -----
// Package for the head pose to quaternion block: types, constants and tables.
// No dependencies.
`timescale 1ns / 1ps

package hpq_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int ATAN_LEN = 24;

    localparam int XY_W = 33;
    localparam int Z_W = 34;
    localparam int SC_W = 22;
    localparam int PAIR_W = 44;
    localparam int TERM_W = 64;
    localparam int NUM_W = 29;
    localparam int POS_W = 23;
    localparam int Q_W = 16;

    localparam logic signed [XY_W-1:0] INV_GAIN_Q30 = 33'sd652032874;
    localparam logic signed [Z_W-1:0] PI_Q30 = 34'sd3373259426;
    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

    // Reciprocal of 125 scaled by 2^36, rounded up.
    localparam logic [29:0] RECIP_125 = 30'd549755814;
    localparam int RECIP_SHIFT = 36;
    localparam logic [NUM_W-1:0] ROUND_BIAS = 29'd62;

    localparam logic signed [Q_W-1:0] Q_MAX = 16'sd16384;
    localparam logic signed [Q_W-1:0] Q_MIN = -16'sd16384;

    typedef enum logic {
        CFG_CONNECTED = 1'b0,
        CFG_CROUCH    = 1'b1
    } cfg_index_t;

    localparam logic [29:0] ATAN_Q30 [0:ATAN_LEN-1] = '{
        30'd843314856, 30'd497837829, 30'd263043836, 30'd133525158,
        30'd67021686,  30'd33543515,  30'd16775850,  30'd8388437,
        30'd4194282,   30'd2097149,   30'd1048575,   30'd524287,
        30'd262143,    30'd131071,    30'd65535,     30'd32767,
        30'd16383,     30'd8191,      30'd4095,      30'd2047,
        30'd1023,      30'd511,       30'd255,       30'd127
    };

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   neg_cos;
    } cordic_t;

    typedef struct packed {
        logic [2:0][NUM_W-1:0] num;
        logic [2:0]            neg;
        logic                  crouch;
    } side_t;

endpackage

// ----- hdl/head_pose_to_quaternion.sv -----
// Throughput: one word per cycle; the pipeline holds only while a finished
// output word is not taken.
// The rotation path is a row of CORDIC_STAGES cells per angle, then multipliers.
// Reset clears the configuration registers and all valid bits.
// Top level; depends on hpq_pkg, hpq_cordic_cell, hpq_term and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module head_pose_to_quaternion #(
    parameter int CORDIC_STAGES = hpq_pkg::CORDIC_STAGES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [17:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] yaw_angle,
    input  logic signed [15:0] pitch_angle,
    input  logic signed [15:0] roll_angle,
    input  logic signed [15:0] pos_x_mm,
    input  logic signed [15:0] pos_y_mm,
    input  logic signed [15:0] pos_z_mm,
    input  logic               crouch_held,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               pose_status,
    output logic signed [15:0] quat_w,
    output logic signed [15:0] quat_x,
    output logic signed [15:0] quat_y,
    output logic signed [15:0] quat_z,
    output logic signed [22:0] out_pos_0,
    output logic signed [22:0] out_pos_1,
    output logic signed [22:0] out_pos_2
);

    localparam int S = CORDIC_STAGES;
    localparam int VLD_N = S + 5;
    localparam int XY_W = hpq_pkg::XY_W;
    localparam int Z_W = hpq_pkg::Z_W;
    localparam int SC_W = hpq_pkg::SC_W;
    localparam int PAIR_W = hpq_pkg::PAIR_W;
    localparam int TERM_W = hpq_pkg::TERM_W;
    localparam int NUM_W = hpq_pkg::NUM_W;
    localparam int POS_W = hpq_pkg::POS_W;

    logic adv;
    logic connected_reg;
    logic [17:0] crouch_reg;
    logic [VLD_N-1:0] vld_reg;
    logic out_valid_reg;

    hpq_pkg::cordic_t fold_next [0:2];
    hpq_pkg::cordic_t fold_reg [0:2];
    hpq_pkg::cordic_t chain [0:2][0:S];
    hpq_pkg::side_t side_next;
    hpq_pkg::side_t side_reg [0:S];

    logic signed [15:0] ang [0:2];
    logic signed [15:0] mm [0:2];
    logic signed [Z_W-1:0] z_raw [0:2];
    logic [16:0] mag [0:2];

    assign adv = !out_valid_reg || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            connected_reg <= 1'b0;
            crouch_reg    <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                hpq_pkg::CFG_CONNECTED: connected_reg <= cfg_data[0];
                hpq_pkg::CFG_CROUCH:    crouch_reg <= cfg_data;
                default:                connected_reg <= connected_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[VLD_N-2:0], in_valid};
            out_valid_reg <= vld_reg[VLD_N-1];
        end
    end

    // Entry stage: scale and fold the half angles, set up position numerators.
    always_comb
    begin
        ang[0] = roll_angle;
        ang[1] = yaw_angle;
        ang[2] = pitch_angle;
        mm[0] = pos_x_mm;
        mm[1] = pos_z_mm;
        mm[2] = pos_y_mm;
        for (int k = 0; k < 3; k++)
        begin
            z_raw[k] = $signed({{(Z_W-16){ang[k][15]}}, ang[k]}) <<< 16;
            if (k == 1)
            begin
                z_raw[k] = -z_raw[k];
            end
            fold_next[k].x = hpq_pkg::INV_GAIN_Q30;
            fold_next[k].y = '0;
            if (z_raw[k] > hpq_pkg::HALF_PI_Q30)
            begin
                fold_next[k].z = hpq_pkg::PI_Q30 - z_raw[k];
                fold_next[k].neg_cos = 1'b1;
            end
            else if (z_raw[k] < -hpq_pkg::HALF_PI_Q30)
            begin
                fold_next[k].z = -hpq_pkg::PI_Q30 - z_raw[k];
                fold_next[k].neg_cos = 1'b1;
            end
            else
            begin
                fold_next[k].z = z_raw[k];
                fold_next[k].neg_cos = 1'b0;
            end
            mag[k] = mm[k][15] ? 17'(-$signed({mm[k][15], mm[k]})) : 17'(mm[k]);
            side_next.num[k] = {mag[k][15:0], 13'd0} + hpq_pkg::ROUND_BIAS;
            side_next.neg[k] = mm[k][15];
        end
        side_next.crouch = crouch_held;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                fold_reg[k] <= fold_next[k];
            end
            side_reg[0] <= side_next;
            for (int j = 1; j <= S; j++)
            begin
                side_reg[j] <= side_reg[j-1];
            end
        end
    end

    genvar gk, gi;
    generate
        for (gk = 0; gk < 3; gk++)
        begin : g_row
            assign chain[gk][0] = fold_reg[gk];
            for (gi = 0; gi < S; gi++)
            begin : g_cell
                hpq_cordic_cell #(
                    .IDX(gi)
                ) u_cell (
                    .clk (clk),
                    .en  (adv),
                    .din (chain[gk][gi]),
                    .dout(chain[gk][gi+1])
                );
            end
        end
    endgenerate

    // Rounding stage: sine and cosine to Q.20, position quotient.
    logic signed [SC_W-1:0] cos_reg [0:2];
    logic signed [SC_W-1:0] sin_reg [0:2];
    logic signed [SC_W-1:0] cos_next [0:2];
    logic signed [SC_W-1:0] sin_next [0:2];
    logic signed [XY_W:0] cx [0:2];
    logic signed [XY_W:0] sy [0:2];
    logic [NUM_W+29:0] prod [0:2];
    logic [21:0] quo_reg [0:2];
    logic [21:0] quo_next [0:2];
    logic [2:0] neg_reg;
    logic crouch_r_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            cx[k] = chain[k][S].neg_cos ? -$signed({chain[k][S].x[XY_W-1], chain[k][S].x})
                                        : $signed({chain[k][S].x[XY_W-1], chain[k][S].x});
            cx[k] = cx[k] + 34'sd512;
            sy[k] = $signed({chain[k][S].y[XY_W-1], chain[k][S].y}) + 34'sd512;
            cos_next[k] = cx[k][31:10];
            sin_next[k] = sy[k][31:10];
            prod[k] = side_reg[S].num[k] * hpq_pkg::RECIP_125;
            quo_next[k] = prod[k][hpq_pkg::RECIP_SHIFT+21:hpq_pkg::RECIP_SHIFT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < 3; k++)
            begin
                cos_reg[k] <= cos_next[k];
                sin_reg[k] <= sin_next[k];
                quo_reg[k] <= quo_next[k];
            end
            neg_reg      <= side_reg[S].neg;
            crouch_r_reg <= side_reg[S].crouch;
        end
    end

    // Pair stage: products of the first two slots, signed positions.
    logic signed [PAIR_W-1:0] cbca_reg, sbsa_reg, sbca_reg, cbsa_reg;
    logic signed [SC_W-1:0] cc_reg, sc_reg;
    logic signed [POS_W-1:0] pos_p_next [0:2];
    logic signed [POS_W-1:0] pos_p_reg [0:2];
    logic signed [POS_W-1:0] pos_t_reg [0:2];
    logic signed [POS_W-1:0] pos_m_reg [0:2];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            pos_p_next[k] = neg_reg[k] ? -$signed({1'b0, quo_reg[k]}) : $signed({1'b0, quo_reg[k]});
        end
        if (crouch_r_reg)
        begin
            pos_p_next[1] = pos_p_next[1] - $signed({5'd0, crouch_reg});
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cbca_reg <= cos_reg[1] * cos_reg[0];
            sbsa_reg <= sin_reg[1] * sin_reg[0];
            sbca_reg <= sin_reg[1] * cos_reg[0];
            cbsa_reg <= cos_reg[1] * sin_reg[0];
            cc_reg   <= cos_reg[2];
            sc_reg   <= sin_reg[2];
            for (int k = 0; k < 3; k++)
            begin
                pos_p_reg[k] <= pos_p_next[k];
                pos_t_reg[k] <= pos_p_reg[k];
                pos_m_reg[k] <= pos_t_reg[k];
            end
        end
    end

    logic signed [TERM_W-1:0] t_w0, t_w1, t_x0, t_x1, t_y0, t_y1, t_z0, t_z1;

    hpq_term u_w0 (.clk(clk), .en(adv), .pair(cbca_reg), .factor(cc_reg), .term(t_w0));
    hpq_term u_w1 (.clk(clk), .en(adv), .pair(sbsa_reg), .factor(sc_reg), .term(t_w1));
    hpq_term u_x0 (.clk(clk), .en(adv), .pair(cbca_reg), .factor(sc_reg), .term(t_x0));
    hpq_term u_x1 (.clk(clk), .en(adv), .pair(sbsa_reg), .factor(cc_reg), .term(t_x1));
    hpq_term u_y0 (.clk(clk), .en(adv), .pair(sbca_reg), .factor(cc_reg), .term(t_y0));
    hpq_term u_y1 (.clk(clk), .en(adv), .pair(cbsa_reg), .factor(sc_reg), .term(t_y1));
    hpq_term u_z0 (.clk(clk), .en(adv), .pair(cbsa_reg), .factor(cc_reg), .term(t_z0));
    hpq_term u_z1 (.clk(clk), .en(adv), .pair(sbca_reg), .factor(sc_reg), .term(t_z1));

    // Output stage: sum, round to Q1.14, saturate; zero the outputs while not connected.
    logic signed [TERM_W-1:0] qsum [0:3];
    logic signed [17:0] qrnd [0:3];
    logic signed [15:0] q_next [0:3];
    logic signed [15:0] q_reg [0:3];
    logic signed [POS_W-1:0] pos_o_reg [0:2];
    logic status_reg;

    always_comb
    begin
        qsum[0] = t_w0 + t_w1;
        qsum[1] = t_x0 - t_x1;
        qsum[2] = t_y0 + t_y1;
        qsum[3] = t_z0 - t_z1;
        for (int k = 0; k < 4; k++)
        begin
            qsum[k] = qsum[k] + (64'sd1 <<< 45);
            qrnd[k] = qsum[k][63:46];
            if (qrnd[k] > 18'sd16384)
            begin
                q_next[k] = hpq_pkg::Q_MAX;
            end
            else if (qrnd[k] < -18'sd16384)
            begin
                q_next[k] = hpq_pkg::Q_MIN;
            end
            else
            begin
                q_next[k] = qrnd[k][15:0];
            end
            if (!connected_reg)
            begin
                q_next[k] = '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            status_reg <= connected_reg;
            for (int k = 0; k < 4; k++)
            begin
                q_reg[k] <= q_next[k];
            end
            for (int k = 0; k < 3; k++)
            begin
                pos_o_reg[k] <= connected_reg ? pos_m_reg[k] : '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign pose_status = status_reg;
    assign quat_w      = q_reg[0];
    assign quat_x      = q_reg[1];
    assign quat_y      = q_reg[2];
    assign quat_z      = q_reg[3];
    assign out_pos_0   = pos_o_reg[0];
    assign out_pos_1   = pos_o_reg[1];
    assign out_pos_2   = pos_o_reg[2];

    `HPQ_ASSERT(a_last_stage_lands, vld_reg[VLD_N-1] && adv |=> out_valid)
    `HPQ_ASSERT(a_quat_saturated, out_valid |-> quat_w <= 16'sd16384 && quat_w >= -16'sd16384)
    `HPQ_ASSERT(a_stall_blocks_input, out_valid && !out_ready |-> !in_ready)
    `HPQ_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid || rst_n)

endmodule

// ----- hdl/hpq_cordic_cell.sv -----
// One rotation-mode CORDIC iteration with its pipeline register.
// Depends on hpq_pkg.
`timescale 1ns / 1ps

module hpq_cordic_cell #(
    parameter int IDX = 0
) (
    input  logic             clk,
    input  logic             en,
    input  hpq_pkg::cordic_t din,
    output hpq_pkg::cordic_t dout
);

    localparam logic signed [hpq_pkg::Z_W-1:0] ATAN =
        hpq_pkg::Z_W'(hpq_pkg::ATAN_Q30[IDX]);

    hpq_pkg::cordic_t data_reg;
    hpq_pkg::cordic_t data_next;
    logic signed [hpq_pkg::XY_W-1:0] dx;
    logic signed [hpq_pkg::XY_W-1:0] dy;

    always_comb
    begin
        dx = din.y >>> IDX;
        dy = din.x >>> IDX;
        data_next.neg_cos = din.neg_cos;
        if (!din.z[hpq_pkg::Z_W-1])
        begin
            data_next.x = din.x - dx;
            data_next.y = din.y + dy;
            data_next.z = din.z - ATAN;
        end
        else
        begin
            data_next.x = din.x + dx;
            data_next.y = din.y - dy;
            data_next.z = din.z + ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign dout = data_reg;

endmodule

// ----- hdl/hpq_term.sv -----
// Two-stage product of a 44-bit pair product and a 22-bit factor, split in halves.
// Depends on hpq_pkg.
`timescale 1ns / 1ps

module hpq_term (
    input  logic                                 clk,
    input  logic                                 en,
    input  logic signed [hpq_pkg::PAIR_W-1:0]    pair,
    input  logic signed [hpq_pkg::SC_W-1:0]      factor,
    output logic signed [hpq_pkg::TERM_W-1:0]    term
);

    logic signed [21:0] hi_part;
    logic signed [22:0] lo_part;
    logic signed [43:0] hi_reg;
    logic signed [43:0] hi_next;
    logic signed [44:0] lo_reg;
    logic signed [44:0] lo_next;
    logic signed [hpq_pkg::TERM_W-1:0] term_reg;
    logic signed [hpq_pkg::TERM_W-1:0] term_next;

    always_comb
    begin
        hi_part = pair[43:22];
        lo_part = $signed({1'b0, pair[21:0]});
        hi_next = hi_part * factor;
        lo_next = lo_part * factor;
        term_next = ($signed({{20{hi_reg[43]}}, hi_reg}) <<< 22)
                  + $signed({{19{lo_reg[44]}}, lo_reg});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hi_reg   <= hi_next;
            lo_reg   <= lo_next;
            term_reg <= term_next;
        end
    end

    assign term = term_reg;

endmodule
